[rtl/core/msw_pkg.sv]
// Package for the mixed-radix stopwatch: field widths, command codes,
// digit limits, the seven-segment table and the structs shared by the modules.
// No dependencies.
package msw_pkg;

  localparam int CMD_W   = 3;
  localparam int HOLD_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int DEC_W   = 4;
  localparam int HEX_W   = 3;
  localparam int SEG_W   = 8;

  localparam logic [CMD_W-1:0] CMD_COUNT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BLINK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PRESS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UART    = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;

  // Largest value each digit holds before it wraps.
  localparam logic [DEC_W-1:0] UNITS_MAX  = 4'd9;
  localparam logic [HEX_W-1:0] SECOND_MAX = 3'd5;
  localparam logic [DEC_W-1:0] THIRD_MAX  = 4'd9;
  localparam logic [HEX_W-1:0] TOP_MAX    = 3'd5;

  localparam logic [HOLD_W-1:0] LONG_PRESS_RST = 16'd2000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [HOLD_W-1:0] hold_ms;
    logic [CHAR_W-1:0] rx_char;
  } item_t;

  // Active-low segment pattern; anything above nine lights every segment.
  function automatic logic [SEG_W-1:0] seg_of(input logic [DEC_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'b1000_0001;
      4'd1:    s = 8'b1111_0011;
      4'd2:    s = 8'b0100_1001;
      4'd3:    s = 8'b0110_0001;
      4'd4:    s = 8'b0011_0011;
      4'd5:    s = 8'b0010_0101;
      4'd6:    s = 8'b0000_0101;
      4'd7:    s = 8'b1111_0001;
      4'd8:    s = 8'b0000_0001;
      4'd9:    s = 8'b0010_0001;
      default: s = 8'b0000_0000;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/msw_if.sv]
// Handshake channels of the stopwatch: input words, result words and the
// configuration write channel. Depends on msw_pkg.
interface msw_in_if;
  import msw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [HOLD_W-1:0] hold_ms;
  logic [CHAR_W-1:0] rx_char;
  modport source (output valid, cmd, hold_ms, rx_char, input ready);
  modport sink   (input valid, cmd, hold_ms, rx_char, output ready);
endinterface

interface msw_out_if;
  import msw_pkg::*;
  logic             valid;
  logic             ready;
  logic [DEC_W-1:0] units_digit;
  logic [HEX_W-1:0] second_digit;
  logic [DEC_W-1:0] third_digit;
  logic [HEX_W-1:0] top_digit;
  logic [SEG_W-1:0] units_segments;
  logic [SEG_W-1:0] second_segments;
  logic [SEG_W-1:0] third_segments;
  logic [SEG_W-1:0] top_segments;
  logic             running;
  logic             led_on;
  logic             cleared;
  modport source (output valid, units_digit, second_digit, third_digit, top_digit,
                  units_segments, second_segments, third_segments, top_segments,
                  running, led_on, cleared, input ready);
  modport sink   (input valid, units_digit, second_digit, third_digit, top_digit,
                  units_segments, second_segments, third_segments, top_segments,
                  running, led_on, cleared, output ready);
endinterface

interface msw_cfg_if;
  import msw_pkg::*;
  logic              valid;
  logic              ready;
  logic [HOLD_W-1:0] long_press_ms;
  modport source (output valid, long_press_ms, input ready);
  modport sink   (input valid, long_press_ms, output ready);
endinterface

[rtl/core/msw_in_reg.sv]
// Input register of the stopwatch: holds one accepted word until the
// update stage takes it. Depends on msw_pkg and msw_in_if.
module msw_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  msw_in_if.sink          in_if,
  input  logic            take,
  output logic            item_valid,
  output msw_pkg::item_t  item
);
  import msw_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_if.ready = !valid_r || take;
  assign valid_nxt   = in_if.valid ? 1'b1 : (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.cmd     <= in_if.cmd;
      item_r.hold_ms <= in_if.hold_ms;
      item_r.rx_char <= in_if.rx_char;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[rtl/core/msw_engine.sv]
// Stopwatch state, its combinational update for a word and the result register.
// Depends on msw_pkg and msw_out_if.
module msw_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  msw_pkg::item_t             item,
  input  logic [msw_pkg::HOLD_W-1:0] long_press_ms,
  output logic                       take,
  msw_out_if.source                  out_if
);
  import msw_pkg::*;

  logic [DEC_W-1:0] units_r, units_nxt;
  logic [HEX_W-1:0] second_r, second_nxt;
  logic [DEC_W-1:0] third_r, third_nxt;
  logic [HEX_W-1:0] top_r, top_nxt;
  logic             run_r, run_nxt;
  logic             idle_r, idle_nxt;
  logic             led_r, led_nxt;
  logic             clear;
  logic             c_units, c_second, c_third;
  logic             out_valid_r;

  assign take = item_valid && (!out_valid_r || out_if.ready);

  // Carry out of each digit on a count tick.
  assign c_units  = (units_r == UNITS_MAX);
  assign c_second = c_units && (second_r == SECOND_MAX);
  assign c_third  = c_second && (third_r == THIRD_MAX);

  always_comb begin
    units_nxt  = units_r;
    second_nxt = second_r;
    third_nxt  = third_r;
    top_nxt    = top_r;
    run_nxt    = run_r;
    idle_nxt   = idle_r;
    led_nxt    = led_r;
    clear      = 1'b0;
    case (item.cmd)
      CMD_COUNT: begin
        if (run_r) begin
          if (c_third && (top_r == TOP_MAX)) begin
            clear = 1'b1;
          end else begin
            units_nxt = c_units ? '0 : units_r + 1'b1;
            if (c_units) begin
              second_nxt = c_second ? '0 : second_r + 1'b1;
            end
            if (c_second) begin
              third_nxt = c_third ? '0 : third_r + 1'b1;
            end
            if (c_third) begin
              top_nxt = top_r + 1'b1;
            end
          end
        end
      end
      CMD_BLINK: begin
        if (idle_r) begin
          led_nxt = 1'b0;
        end else if (run_r) begin
          led_nxt = !led_r;
        end else begin
          led_nxt = 1'b1;
        end
      end
      CMD_PRESS: begin
        run_nxt  = !run_r;
        idle_nxt = 1'b0;
      end
      CMD_RELEASE: begin
        clear = (item.hold_ms >= long_press_ms);
      end
      CMD_UART: begin
        if (item.rx_char == CHAR_ONE) begin
          run_nxt  = !run_r;
          idle_nxt = 1'b0;
        end else if (item.rx_char == CHAR_ZERO && !run_r) begin
          clear = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (clear) begin
      units_nxt  = '0;
      second_nxt = '0;
      third_nxt  = '0;
      top_nxt    = '0;
      run_nxt    = 1'b0;
      idle_nxt   = 1'b1;
      led_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r     <= '0;
      second_r    <= '0;
      third_r     <= '0;
      top_r       <= '0;
      run_r       <= 1'b0;
      idle_r      <= 1'b1;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        units_r  <= units_nxt;
        second_r <= second_nxt;
        third_r  <= third_nxt;
        top_r    <= top_nxt;
        run_r    <= run_nxt;
        idle_r   <= idle_nxt;
        led_r    <= led_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word; the segment codes are looked up before the register.
  always_ff @(posedge clk) begin
    if (take) begin
      out_if.units_digit     <= units_nxt;
      out_if.second_digit    <= second_nxt;
      out_if.third_digit     <= third_nxt;
      out_if.top_digit       <= top_nxt;
      out_if.units_segments  <= seg_of(units_nxt);
      out_if.second_segments <= seg_of({1'b0, second_nxt});
      out_if.third_segments  <= seg_of(third_nxt);
      out_if.top_segments    <= seg_of({1'b0, top_nxt});
      out_if.running         <= run_nxt;
      out_if.led_on          <= led_nxt;
      out_if.cleared         <= clear;
    end
  end

  assign out_if.valid = out_valid_r;

endmodule

[rtl/core/mixed_radix_stopwatch_top.sv]
// Four-digit mixed-radix stopwatch with seven-segment codes.
//
// Channels: in_if takes command words (count tick, blink tick, button press,
// button release with hold time, UART byte). out_if gives one result word per
// command word: the four digits, their active-low segment codes, the running
// flag, the LED level and a flag for a clearing. cfg_if writes the long-press
// threshold in milliseconds; it is always ready. The user must write it only while
// no word is in flight; the block itself does not enforce this.
// A result passes through the input register and then through the update stage
// and result register.
// Throughput: one word per cycle while out_if is not stalled; the update of all
// digits and flags is combinational against the stored state.
// Reset: digits zero, stopped, idle-restart mark set, LED off, threshold 2000.
// When the receiver stalls, the result register holds its word, the input
// register takes one more word, and in_if.ready then falls until the stall
// clears. Depends on msw_pkg, msw_if, msw_in_reg and msw_engine.
module mixed_radix_stopwatch_top (
  input  logic       clk,
  input  logic       rst_n,
  msw_in_if.sink     in_if,
  msw_out_if.source  out_if,
  msw_cfg_if.sink    cfg_if
);
  import msw_pkg::*;

  logic [HOLD_W-1:0] long_press_r;
  logic              item_valid;
  item_t             item;
  logic              take;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      long_press_r <= cfg_if.long_press_ms;
    end
  end

  msw_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  msw_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .long_press_ms (long_press_r),
    .take          (take),
    .out_if        (out_if)
  );

`ifndef ASSERT_OFF
  // A clearing always leaves the watch stopped at zero with the LED off.
  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.cleared) |-> (!out_if.running && !out_if.led_on &&
      out_if.units_digit == '0 && out_if.second_digit == '0 &&
      out_if.third_digit == '0 && out_if.top_digit == '0))
    else $error("clearing result does not show a stopped zero state");

  // Each digit stays inside its own radix.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.units_digit <= UNITS_MAX &&
      out_if.second_digit <= SECOND_MAX && out_if.third_digit <= THIRD_MAX &&
      out_if.top_digit <= TOP_MAX))
    else $error("digit outside its radix");

  // An accepted word is held in the input register on the next cycle.
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> item_valid)
    else $error("accepted word lost from the input register");

  // A word taken by the update stage is always presented as a valid result word.
  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_if.valid)
    else $error("update stage result not presented");
`endif

endmodule

[tb/tb_mixed_radix_stopwatch_top.sv]
// Self-checking testbench for the mixed-radix stopwatch: drives command words with
// random gaps, stalls the result side and checks every result word against a predictor.
// Depends on msw_pkg, the msw_if interfaces and mixed_radix_stopwatch_top.
`timescale 1ns / 100ps

module tb_mixed_radix_stopwatch_top;
  import msw_pkg::*;

  localparam int WD_LIMIT  = 2000;
  localparam int TAIL_CYC  = 4;
  localparam int RAND_WORDS = 270;

  typedef struct {
    logic [DEC_W-1:0] units;
    logic [HEX_W-1:0] second;
    logic [DEC_W-1:0] third;
    logic [HEX_W-1:0] top;
    logic [SEG_W-1:0] units_seg;
    logic [SEG_W-1:0] second_seg;
    logic [SEG_W-1:0] third_seg;
    logic [SEG_W-1:0] top_seg;
    logic             running;
    logic             led;
    logic             cleared;
  } watch_res_t;

  logic clk = 1'b0;
  logic rst_n;

  msw_in_if  in_ch();
  msw_out_if out_ch();
  msw_cfg_if cfg_ch();

  mixed_radix_stopwatch_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5 clk = ~clk;

  // Active-low glyphs for the digits nought to nine.
  logic [SEG_W-1:0] glyph_rom [10] = '{8'h81, 8'hF3, 8'h49, 8'h61, 8'h33,
                                       8'h25, 8'h05, 8'hF1, 8'h01, 8'h21};

  // Predicted stopwatch state and threshold.
  logic [DEC_W-1:0]  st_units, st_third;
  logic [HEX_W-1:0]  st_second, st_top;
  bit                st_run, st_idle, st_led;
  logic [HOLD_W-1:0] thr_ms = LONG_PRESS_RST;

  item_t             cmd_backlog[$];
  logic [HOLD_W-1:0] thr_backlog[$];
  watch_res_t        exp_readings[$];
  item_t             on_bus;
  logic [HOLD_W-1:0] thr_on_bus;
  bit                carrying, thr_busy, idle_on;
  int                gap_left, stall_left, idle_cyc;
  int                err_cnt, n_words, n_results, n_clear, n_overflow, n_thr;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void wipe_watch();
    st_units  = '0;
    st_second = '0;
    st_third  = '0;
    st_top    = '0;
    st_run    = 1'b0;
    st_idle   = 1'b1;
    st_led    = 1'b0;
  endfunction

  // One count tick through the digit chain; returns one when the top digit overflows.
  function automatic bit tick_digits();
    if (st_units != UNITS_MAX) begin
      st_units++;
      return 1'b0;
    end
    st_units = '0;
    if (st_second != SECOND_MAX) begin
      st_second++;
      return 1'b0;
    end
    st_second = '0;
    if (st_third != THIRD_MAX) begin
      st_third++;
      return 1'b0;
    end
    st_third = '0;
    if (st_top != TOP_MAX) begin
      st_top++;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic watch_res_t step_watch(input item_t w);
    watch_res_t r;
    bit         wiped;
    wiped = 1'b0;
    case (w.cmd)
      CMD_COUNT: begin
        if (st_run && tick_digits()) begin
          wipe_watch();
          wiped = 1'b1;
          n_overflow++;
        end
      end
      CMD_BLINK: begin
        if (st_idle) st_led = 1'b0;
        else if (st_run) st_led = ~st_led;
        else st_led = 1'b1;
      end
      CMD_PRESS: begin
        st_run  = ~st_run;
        st_idle = 1'b0;
      end
      CMD_RELEASE: begin
        if (w.hold_ms >= thr_ms) begin
          wipe_watch();
          wiped = 1'b1;
        end
      end
      CMD_UART: begin
        if (w.rx_char == CHAR_ONE) begin
          st_run  = ~st_run;
          st_idle = 1'b0;
        end else if (w.rx_char == CHAR_ZERO && !st_run) begin
          wipe_watch();
          wiped = 1'b1;
        end
      end
      default: ;
    endcase
    if (wiped) n_clear++;
    r.units      = st_units;
    r.second     = st_second;
    r.third      = st_third;
    r.top        = st_top;
    r.units_seg  = glyph_rom[st_units];
    r.second_seg = glyph_rom[{1'b0, st_second}];
    r.third_seg  = glyph_rom[st_third];
    r.top_seg    = glyph_rom[{1'b0, st_top}];
    r.running    = st_run;
    r.led        = st_led;
    r.cleared    = wiped;
    return r;
  endfunction

  function automatic item_t rand_word();
    item_t w;
    int    pick, h;
    w.cmd     = CMD_COUNT;
    w.hold_ms = HOLD_W'($urandom);
    w.rx_char = CHAR_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) w.cmd = CMD_COUNT;
    else if (pick < 67) w.cmd = CMD_BLINK;
    else if (pick < 75) w.cmd = CMD_PRESS;
    else if (pick < 87) begin
      w.cmd = CMD_RELEASE;
      h = $urandom_range(0, 9);
      if (h == 6) w.hold_ms = '0;
      else if (h == 7) w.hold_ms = '1;
      else if (h >= 8) w.hold_ms = HOLD_W'($urandom_range(0, 4000));
      else if (h >= 3) begin
        // Straddle the threshold so both sides of the comparison are hit.
        h = int'(thr_ms) + int'($urandom_range(0, 2)) - 1;
        if (h < 0) h = 0;
        if (h > 65535) h = 65535;
        w.hold_ms = HOLD_W'(h);
      end
    end else if (pick < 97) begin
      w.cmd = CMD_UART;
      h = $urandom_range(0, 9);
      if (h < 4) w.rx_char = CHAR_ONE;
      else if (h < 7) w.rx_char = CHAR_ZERO;
    end else begin
      w.cmd = CMD_W'($urandom_range(5, 7));
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                n_results, name, got, want));
  endtask

  task automatic queue_word(input logic [CMD_W-1:0] c, input logic [HOLD_W-1:0] h,
                            input logic [CHAR_W-1:0] ch);
    item_t w;
    w.cmd     = c;
    w.hold_ms = h;
    w.rx_char = ch;
    cmd_backlog.push_back(w);
  endtask

  // Wait until every word is sent and every result is in, then let the pipeline settle.
  task automatic drain();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || carrying || exp_readings.size() != 0);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [HOLD_W-1:0] v);
    thr_backlog.push_back(v);
    do @(posedge clk);
    while (thr_backlog.size() != 0 || thr_busy);
  endtask

  // Command word driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
      carrying = 1'b0;
      wipe_watch();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        exp_readings.push_back(step_watch(on_bus));
        carrying = 1'b0;
        n_words++;
        if (idle_on && $urandom_range(0, 3) == 0) gap_left = idle_len();
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          on_bus = cmd_backlog.pop_front();
          carrying = 1'b1;
          in_ch.valid   <= 1'b1;
          in_ch.cmd     <= on_bus.cmd;
          in_ch.hold_ms <= on_bus.hold_ms;
          in_ch.rx_char <= on_bus.rx_char;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Threshold write channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
      thr_busy = 1'b0;
      thr_ms   = LONG_PRESS_RST;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        thr_ms   = thr_on_bus;
        thr_busy = 1'b0;
        n_thr++;
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (thr_backlog.size() != 0) begin
          thr_on_bus = thr_backlog.pop_front();
          thr_busy = 1'b1;
          cfg_ch.valid         <= 1'b1;
          cfg_ch.long_press_ms <= thr_on_bus;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin : result_mon
    watch_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (exp_readings.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = exp_readings.pop_front();
          check_field("units_digit", 16'(out_ch.units_digit), 16'(want.units));
          check_field("second_digit", 16'(out_ch.second_digit), 16'(want.second));
          check_field("third_digit", 16'(out_ch.third_digit), 16'(want.third));
          check_field("top_digit", 16'(out_ch.top_digit), 16'(want.top));
          check_field("units_segments", 16'(out_ch.units_segments),
                      16'(want.units_seg));
          check_field("second_segments", 16'(out_ch.second_segments),
                      16'(want.second_seg));
          check_field("third_segments", 16'(out_ch.third_segments),
                      16'(want.third_seg));
          check_field("top_segments", 16'(out_ch.top_segments), 16'(want.top_seg));
          check_field("running", 16'(out_ch.running), 16'(want.running));
          check_field("led_on", 16'(out_ch.led_on), 16'(want.led));
          check_field("cleared", 16'(out_ch.cleared), 16'(want.cleared));
        end
        n_results++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cyc = 0;
      else
        idle_cyc++;
      if (idle_cyc == WD_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 WD_LIMIT, exp_readings.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [HOLD_W-1:0] thr_plan [6];
    rst_n    = 1'b0;
    idle_on  = 1'b1;
    idle_cyc = 0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = '0;
    in_ch.hold_ms = '0;
    in_ch.rx_char = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.long_press_ms = '0;
    out_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening with the reset threshold of 2000 ms.
    queue_word(CMD_BLINK, 16'd0, 8'd0);
    queue_word(CMD_COUNT, 16'd0, 8'd0);
    queue_word(CMD_RELEASE, 16'd0, 8'd0);
    queue_word(CMD_RELEASE, 16'hFFFF, 8'hFF);
    queue_word(CMD_UART, 16'd0, CHAR_ZERO);
    queue_word(CMD_PRESS, 16'd0, 8'd0);
    queue_word(CMD_BLINK, 16'd0, 8'd0);
    queue_word(CMD_BLINK, 16'd0, 8'd0);
    queue_word(CMD_COUNT, 16'd0, 8'd0);
    queue_word(CMD_UART, 16'd0, CHAR_ZERO);
    queue_word(CMD_UART, 16'hFFFF, 8'h00);
    queue_word(CMD_UART, 16'd0, 8'hFF);
    queue_word(CMD_UART, 16'd0, CHAR_ONE);
    queue_word(CMD_BLINK, 16'd0, 8'd0);
    queue_word(3'd5, 16'd0, 8'd0);
    queue_word(3'd6, 16'hFFFF, 8'hFF);
    queue_word(3'd7, 16'hFFFF, CHAR_ZERO);
    queue_word(CMD_RELEASE, 16'd1999, 8'd0);
    queue_word(CMD_RELEASE, 16'd2000, 8'd0);
    queue_word(CMD_UART, 16'd0, CHAR_ONE);
    queue_word(CMD_PRESS, 16'd0, 8'd0);
    queue_word(CMD_COUNT, 16'd0, 8'd0);
    queue_word(CMD_RELEASE, 16'd2001, 8'd0);
    drain();

    thr_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd2000, 16'h8000};
    thr_plan[3] = HOLD_W'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(thr_plan[ph]);
      idle_on = (ph % 3 != 2);
      for (int k = 0; k < RAND_WORDS; k++) cmd_backlog.push_back(rand_word());
      drain();
      if (ph == 1) begin
        // Full run to 59:59 and one tick beyond, with stray blink ticks mixed in.
        idle_on = 1'b1;
        queue_word(CMD_RELEASE, 16'hFFFF, 8'd0);
        queue_word(CMD_PRESS, HOLD_W'($urandom), CHAR_W'($urandom));
        for (int k = 0; k < 3600; k++) begin
          if ($urandom_range(0, 19) == 0)
            queue_word(CMD_BLINK, HOLD_W'($urandom), CHAR_W'($urandom));
          queue_word(CMD_COUNT, HOLD_W'($urandom), CHAR_W'($urandom));
        end
        queue_word(CMD_BLINK, 16'd0, 8'd0);
        queue_word(CMD_COUNT, 16'd0, 8'd0);
        queue_word(CMD_UART, 16'd0, CHAR_ONE);
        drain();
      end
    end

    $display("Sent %0d command words under %0d threshold writes; %0d results checked.",
             n_words, n_thr, n_results);
    $display("Clearings seen: %0d, of which %0d were overflows past 59:59.",
             n_clear, n_overflow);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/msw_pkg.sv
rtl/core/msw_if.sv
rtl/core/msw_in_reg.sv
rtl/core/msw_engine.sv
rtl/core/mixed_radix_stopwatch_top.sv
tb/tb_mixed_radix_stopwatch_top.sv
